FILE: sv/lcffa_pkg.sv
package lcffa_pkg;

    // Grid geometry and owner width.
    localparam int MAX_CHUNKS = 64;
    localparam int MAX_LEVELS = 16;
    localparam int ID_BITS    = 8;

    // Derived widths: row address, row count (0..MAX_CHUNKS), level count.
    localparam int ROW_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int ROWCNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int LVLCNT_W = $clog2(MAX_LEVELS + 1);
    localparam int ROW_BITS = MAX_LEVELS * ID_BITS;

    // Configuration register indexes.
    localparam int          CFG_IDX_W  = 2;
    localparam logic [1:0]  CFG_CHUNKS = 2'd0;
    localparam logic [1:0]  CFG_LEVELS = 2'd1;
    localparam logic [1:0]  CFG_EMPTY  = 2'd2;

    // Request opcodes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_ALIAS = 2'd2;
    localparam logic [1:0] OP_USED  = 2'd3;

    // Response status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADREQ  = 2'd2;

    typedef logic [ID_BITS-1:0]                   t_id;
    typedef logic [MAX_LEVELS-1:0][ID_BITS-1:0]   t_row;
    typedef logic [MAX_LEVELS-1:0]                t_lmask;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] item_id;
        logic [6:0] chunk_count;
        logic [3:0] start_level;
        logic [3:0] last_level;
        logic [5:0] chunk_offset;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_offset;
        logic       aliased;
        logic [6:0] used_chunks;
    } t_rsp;

    // Effective configuration handed to the engine.
    typedef struct packed {
        logic [ROWCNT_W-1:0] nch;
        logic [LVLCNT_W-1:0] nlv;
        t_id                 empty;
    } t_cfg;

    // Fit an 8-bit field into an owner ID (truncate or zero-extend).
    function automatic t_id to_id(input logic [7:0] v);
        t_id r;
        r = '0;
        for (int i = 0; i < ID_BITS; i++) begin
            if (i < 8) begin
                r[i] = v[i % 8];
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/lcffa_ram.sv
module lcffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lcffa_engine.sv
module lcffa_engine import lcffa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_WRD  = 3'd3;
    localparam logic [2:0] S_WRM  = 3'd4;

    logic [2:0]            r_state, n_state;
    t_req                  r_req, n_req;
    t_lmask                r_in_mask, n_in_mask;
    t_lmask                r_out_mask, n_out_mask;
    t_lmask                r_any_mask, n_any_mask;
    logic [ROWCNT_W-1:0]   r_row, n_row;
    logic [ROWCNT_W-1:0]   r_end, n_end;
    logic [ROWCNT_W-1:0]   r_run, n_run;
    logic [ROWCNT_W-1:0]   r_used, n_used;
    logic [ROWCNT_W-1:0]   r_found, n_found;
    logic [MAX_CHUNKS-1:0] r_row_vld, n_row_vld;
    t_id                   r_fill, n_fill;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    logic [ROW_W-1:0]      row_addr;
    logic [ROWCNT_W-1:0]   row_nxt;
    logic [ROW_BITS-1:0]   ram_rdata;
    t_row                  row_data;
    t_row                  row_merged;
    t_lmask                busy_vec;
    t_id                   req_id;
    logic                  bad_interval;
    logic                  ram_re;
    logic                  ram_we;

    assign row_addr = r_row[ROW_W-1:0];
    assign row_nxt  = r_row + 1'b1;
    assign req_id   = to_id(r_req.item_id);
    assign ram_re   = (r_state == S_RD) || (r_state == S_WRD);
    assign ram_we   = (r_state == S_WRM);

    // Grid storage: one row per chunk, one ID per level in the row.
    lcffa_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_CHUNKS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (row_addr),
        .i_wdata (row_merged),
        .i_re    (ram_re),
        .i_raddr (row_addr),
        .o_rdata (ram_rdata)
    );

    // A row never written since the last clear reads as the clear value.
    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            row_data[l]   = r_rd_vld ? ram_rdata[l*ID_BITS +: ID_BITS] : r_fill;
            busy_vec[l]   = (row_data[l] != i_cfg.empty);
            row_merged[l] = r_in_mask[l] ? req_id : row_data[l];
        end
    end

    assign bad_interval = (i_req.start_level > i_req.last_level)
                       || (32'(i_req.last_level) >= 32'(i_cfg.nlv));

    // Sequencer: read a row, evaluate it, and for allocate rewrite the run.
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_in_mask  = r_in_mask;
        n_out_mask = r_out_mask;
        n_any_mask = r_any_mask;
        n_row      = r_row;
        n_end      = r_end;
        n_run      = r_run;
        n_used     = r_used;
        n_found    = r_found;
        n_row_vld  = r_row_vld;
        n_fill     = r_fill;
        n_rd_vld   = r_rd_vld;
        n_done     = 1'b0;
        n_rsp      = r_rsp;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    for (int l = 0; l < MAX_LEVELS; l++) begin
                        n_in_mask[l]  = (32'(i_req.start_level) <= l)
                                     && (l <= 32'(i_req.last_level));
                        n_any_mask[l] = (l < 32'(i_cfg.nlv));
                        n_out_mask[l] = n_any_mask[l] && !n_in_mask[l];
                    end
                    n_rsp   = '0;
                    n_run   = '0;
                    n_used  = '0;
                    n_row   = '0;
                    n_state = S_RD;
                    case (i_req.opcode)
                        OP_CLEAR: begin
                            n_row_vld = '0;
                            n_fill    = i_cfg.empty;
                            n_done    = 1'b1;
                            n_state   = S_IDLE;
                        end
                        OP_ALLOC: begin
                            if ((i_req.chunk_count == '0) || bad_interval) begin
                                n_rsp.status = ST_BADREQ;
                                n_done       = 1'b1;
                                n_state      = S_IDLE;
                            end else if (i_cfg.nch == '0) begin
                                n_rsp.status = ST_NOSPACE;
                                n_done       = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end
                        OP_ALIAS: begin
                            if ((i_req.chunk_count == '0) || bad_interval
                                || (32'(i_req.chunk_offset) + 32'(i_req.chunk_count)
                                    > 32'(i_cfg.nch))) begin
                                n_rsp.status = ST_BADREQ;
                                n_done       = 1'b1;
                                n_state      = S_IDLE;
                            end else begin
                                n_row = ROWCNT_W'(i_req.chunk_offset);
                                n_end = ROWCNT_W'(32'(i_req.chunk_offset)
                                                  + 32'(i_req.chunk_count));
                            end
                        end
                        default: begin
                            if (i_cfg.nch == '0) begin
                                n_rsp.used_chunks = 7'd1;
                                n_done            = 1'b1;
                                n_state           = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_RD: begin
                n_rd_vld = r_row_vld[row_addr];
                n_state  = S_EV;
            end

            S_EV: begin
                n_state = S_RD;
                n_row   = row_nxt;
                case (r_req.opcode)
                    OP_ALLOC: begin
                        if ((busy_vec & r_in_mask) == '0) begin
                            n_run = r_run + 1'b1;
                            if (32'(r_run) + 1 == 32'(r_req.chunk_count)) begin
                                n_found = ROWCNT_W'(32'(row_nxt) - 32'(r_req.chunk_count));
                                n_row   = ROWCNT_W'(32'(row_nxt) - 32'(r_req.chunk_count));
                                n_end   = row_nxt;
                                n_state = S_WRD;
                            end
                        end else begin
                            n_run = '0;
                        end
                        if ((n_state == S_RD) && (row_nxt == i_cfg.nch)) begin
                            n_rsp.status = ST_NOSPACE;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_ALIAS: begin
                        if ((busy_vec & r_out_mask) != '0) begin
                            n_rsp.aliased = 1'b1;
                            n_done        = 1'b1;
                            n_state       = S_IDLE;
                        end else if (row_nxt == r_end) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if ((busy_vec & r_any_mask) == '0) begin
                            n_rsp.used_chunks = (r_used == '0) ? 7'd1 : 7'(r_used);
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            n_used = row_nxt;
                            if (row_nxt == i_cfg.nch) begin
                                n_rsp.used_chunks = 7'(row_nxt);
                                n_done            = 1'b1;
                                n_state           = S_IDLE;
                            end
                        end
                    end
                endcase
            end

            S_WRD: begin
                n_rd_vld = r_row_vld[row_addr];
                n_state  = S_WRM;
            end

            // Write-back of the merged row; the next read is always another row.
            S_WRM: begin
                n_row_vld[row_addr] = 1'b1;
                n_row               = row_nxt;
                n_state             = S_WRD;
                if (row_nxt == r_end) begin
                    n_rsp.status       = ST_OK;
                    n_rsp.found_offset = 6'(r_found);
                    n_done             = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; row payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_fill    <= to_id(8'hFF);
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_vld <= n_row_vld;
            r_fill    <= n_fill;
            r_done    <= n_done;
        end
        r_req      <= n_req;
        r_in_mask  <= n_in_mask;
        r_out_mask <= n_out_mask;
        r_any_mask <= n_any_mask;
        r_row      <= n_row;
        r_end      <= n_end;
        r_run      <= n_run;
        r_used     <= n_used;
        r_found    <= n_found;
        r_rd_vld   <= n_rd_vld;
        r_rsp      <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

FILE: sv/lifetime_chunk_first_fit_allocator_unit.sv
// Channel   Direction  Handshake                  Payload
// command   in         start && !busy             i_req  (t_req)
// result    out        o_done, one cycle          o_rsp  (t_rsp)
// config    in         i_cfg_valid && o_cfg_ready i_cfg_index, i_cfg_data
//
// Clear and any refused request give their result in the cycle after the accepting edge.
// Allocate reads and evaluates each scanned chunk row, then reads and rewrites each row of
// the found run; check aliasing and used size read and evaluate each row in turn. Each
// row is read on the single read port of the grid memory. Busy is low in the strobe
// cycle, so the next request can be taken at the edge that ends it. Reset clears the row
// valid flags, so no clearing pass runs. The receiver cannot stall; o_done pulses once
// per request.
module lifetime_chunk_first_fit_allocator_unit import lcffa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_done,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [6:0] r_chunks;
    logic [4:0] r_levels;
    logic [7:0] r_empty;
    t_cfg       cfg;
    logic       cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunks <= 7'd64;
            r_levels <= 5'd16;
            r_empty  <= 8'd255;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_CHUNKS: r_chunks <= i_cfg_data[6:0];
                CFG_LEVELS: r_levels <= i_cfg_data[4:0];
                CFG_EMPTY:  r_empty  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Register values beyond the grid size act as the grid size.
    always_comb begin
        cfg.nch   = (32'(r_chunks) > MAX_CHUNKS) ? ROWCNT_W'(MAX_CHUNKS)
                                                 : ROWCNT_W'(r_chunks);
        cfg.nlv   = (32'(r_levels) > MAX_LEVELS) ? LVLCNT_W'(MAX_LEVELS)
                                                 : LVLCNT_W'(r_levels);
        cfg.empty = to_id(r_empty);
    end

    lcffa_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_start (start && !busy),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    // A result is only shown once the engine has gone back to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request either finishes at once or keeps the engine busy.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request produced neither work nor result");

    // The engine only becomes busy after a request was accepted.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

    // A failed request reports neither an offset nor aliasing.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_OK)) |->
            ((o_rsp.found_offset == '0) && !o_rsp.aliased))
        else $error("failed request carries result data");
`endif

endmodule
